// ===== sv/iqssb_pkg.sv =====
`timescale 1ns / 1ps

package iqssb_pkg;

  localparam int PHASE_W  = 3;
  localparam int SAMPLE_W = 10;
  localparam int GAIN_W   = 4;
  localparam int DATA_W   = 16;

  // working widths of the decimator chain
  localparam int X_W  = SAMPLE_W;
  localparam int XE_W = X_W + 1;
  localparam int S1_W = X_W + 2;
  localparam int S2_W = X_W + 4;
  localparam int D_W  = S2_W + 1;

  localparam int NUM_CH  = 2;
  localparam int I_DEPTH = 7;
  localparam int Q_DEPTH = 14;
  localparam int Q_CENTER = 7;

  // hilbert accumulator and final divide by 128
  localparam int ACC_W   = S2_W + 8;
  localparam int H_SHIFT = 7;

  localparam logic signed [XE_W-1:0]  ADC_OFFSET_C = 512;
  localparam logic signed [ACC_W-1:0] H_C0 = 2;
  localparam logic signed [ACC_W-1:0] H_C2 = 8;
  localparam logic signed [ACC_W-1:0] H_C4 = 21;
  localparam logic signed [ACC_W-1:0] H_C6 = 15;

  localparam logic [PHASE_W-1:0] PH_EMIT    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HILBERT = 3'd7;

  typedef struct packed {
    logic signed [X_W-1:0]  last_raw;
    logic signed [X_W-1:0]  s1_hold;
    logic signed [X_W-1:0]  s1_prev;
    logic signed [S1_W-1:0] s2_hold;
    logic signed [S1_W-1:0] s2_prev;
  } chan_state_t;

  typedef struct packed {
    logic                   valid;
    logic [PHASE_W-1:0]     phase;
    logic signed [S2_W-1:0] sample;
  } stage_t;

endpackage

// ===== sv/iqssb_if.sv =====
`timescale 1ns / 1ps

interface iqssb_in_if;
  logic                              valid;
  logic                              ready;
  logic [iqssb_pkg::SAMPLE_W-1:0]    adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface iqssb_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [iqssb_pkg::DATA_W-1:0] sideband_sum;
  logic signed [iqssb_pkg::DATA_W-1:0] i_sample;
  logic signed [iqssb_pkg::DATA_W-1:0] q_sample;

  modport source (output valid, output sideband_sum, output i_sample, output q_sample,
                  input ready);
  modport sink   (input valid, input sideband_sum, input i_sample, input q_sample,
                  output ready);
endinterface

// ===== sv/iq_decimating_ssb_receiver.sv =====
`timescale 1ns / 1ps
// a result is registered on out_ch after its phase-0 sample has passed stages a and b
// throughput: one sample per cycle while in_ch.ready is high, one result per eight samples;
//   the read-modify-write of the channel state memory sets the pipeline depth
// apart from reset, a phase-0 sample is held off only while an earlier result waits on out_ch
// reset (rst_n low, synchronous) clears phase, gain and the hilbert taps directly, and the other
//   filter state through valid bits on the memories; no clearing pass, ready rises as soon as rst_n is released

module iq_decimating_ssb_receiver #(
  parameter int I_DELAY_DEPTH = iqssb_pkg::I_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [iqssb_pkg::GAIN_W-1:0]   cfg_wr_data,
  iqssb_in_if.sink                       in_ch,
  iqssb_out_if.source                    out_ch
);

  localparam int DATA_W = iqssb_pkg::DATA_W;

  logic [iqssb_pkg::PHASE_W-1:0] phase_r;
  logic [iqssb_pkg::GAIN_W-1:0]  gain_r;
  logic                          in_fire;
  logic                          emit;

  iqssb_pkg::stage_t             b_stage;
  logic signed [iqssb_pkg::S2_W-1:0] i_delayed;
  logic signed [iqssb_pkg::S2_W-1:0] q_center;
  logic signed [DATA_W-1:0]      hilbert;

  logic                          out_valid_r;
  logic signed [DATA_W-1:0]      out_sum_r;
  logic signed [DATA_W-1:0]      out_i_r;
  logic signed [DATA_W-1:0]      out_q_r;

  assign in_ch.ready = rst_n && ((phase_r != iqssb_pkg::PH_EMIT) || !out_valid_r
                                 || out_ch.ready);
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      gain_r  <= '0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_r + 1'b1;
      end
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
    end
  end

  iqssb_decim u_decim (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .adc_sample (in_ch.adc_sample),
    .phase      (phase_r),
    .gain_shift (gain_r),
    .stage      (b_stage)
  );

  iqssb_idelay #(
    .DEPTH (I_DELAY_DEPTH)
  ) u_idelay (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_fire && (phase_r == iqssb_pkg::PH_EMIT)),
    .stage (b_stage),
    .i_out (i_delayed)
  );

  iqssb_hilbert u_hilbert (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (b_stage),
    .hilbert  (hilbert),
    .q_center (q_center)
  );

  assign emit = b_stage.valid && (b_stage.phase == iqssb_pkg::PH_EMIT);

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sum_r <= DATA_W'(i_delayed) + hilbert;
      out_i_r   <= DATA_W'(i_delayed);
      out_q_r   <= DATA_W'(q_center);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sideband_sum = out_sum_r;
  assign out_ch.i_sample     = out_i_r;
  assign out_ch.q_sample     = out_q_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !out_valid_r)
    else $error("result overwrites a pending result");

  a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (phase_r == iqssb_pkg::PH_EMIT)) |=> ##1
      (b_stage.valid && (b_stage.phase == iqssb_pkg::PH_EMIT)))
    else $error("phase-0 sample did not reach the output stage in time");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit))
    else $error("output valid rose without a result");

endmodule

// ===== sv/iqssb_decim.sv =====
`timescale 1ns / 1ps

module iqssb_decim (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  logic [iqssb_pkg::SAMPLE_W-1:0]     adc_sample,
  input  logic [iqssb_pkg::PHASE_W-1:0]      phase,
  input  logic [iqssb_pkg::GAIN_W-1:0]       gain_shift,
  output iqssb_pkg::stage_t                  stage
);

  localparam int X_W    = iqssb_pkg::X_W;
  localparam int XE_W   = iqssb_pkg::XE_W;
  localparam int S1_W   = iqssb_pkg::S1_W;
  localparam int S2_W   = iqssb_pkg::S2_W;
  localparam int NUM_CH = iqssb_pkg::NUM_CH;

  // per-channel filter state, index 0 = I, 1 = Q
  iqssb_pkg::chan_state_t chan_mem_r [NUM_CH];
  logic [NUM_CH-1:0]      chan_vld_r;

  iqssb_pkg::chan_state_t rd_data_r;
  logic                   rd_vld_r;

  logic                             a_valid_r;
  logic [iqssb_pkg::PHASE_W-1:0]    a_phase_r;
  logic signed [X_W-1:0]            a_x_r;

  logic                             b_valid_r;
  logic [iqssb_pkg::PHASE_W-1:0]    b_phase_r;
  logic signed [S2_W-1:0]           b_sample_r;

  logic signed [XE_W-1:0]           x_ext;
  logic signed [X_W-1:0]            x_new;

  iqssb_pkg::chan_state_t cs;
  iqssb_pkg::chan_state_t cs_nxt;
  logic                             is_i;
  logic [iqssb_pkg::PHASE_W-1:0]    sel;
  logic signed [XE_W-1:0]           avg_sum;
  logic signed [XE_W-1:0]           avg_adj;
  logic signed [X_W-1:0]            xv;
  logic signed [S1_W-1:0]           s1;
  logic signed [S2_W-1:0]           s2;
  logic signed [S2_W-1:0]           s2_sh;

  assign x_ext = $signed({1'b0, adc_sample}) - iqssb_pkg::ADC_OFFSET_C;
  assign x_new = x_ext[X_W-1:0];

  // read on transfer, data lands with the item in stage a
  always_ff @(posedge clk) begin
    if (fire) begin
      rd_data_r <= chan_mem_r[phase[0]];
      a_phase_r <= phase;
      a_x_r     <= x_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      a_valid_r <= fire;
      if (fire) begin
        rd_vld_r <= chan_vld_r[phase[0]];
      end
    end
  end

  always_comb begin
    cs      = rd_vld_r ? rd_data_r : '0;
    is_i    = !a_phase_r[0];
    sel     = is_i ? ~a_phase_r : a_phase_r;
    avg_sum = XE_W'(cs.last_raw) + XE_W'(a_x_r);
    // halve with truncation toward zero
    avg_adj = avg_sum + {{(XE_W-1){1'b0}}, avg_sum[XE_W-1]};
    xv      = is_i ? avg_adj[XE_W-1:1] : a_x_r;
    s1      = S1_W'(xv) + S1_W'(cs.s1_prev) + (S1_W'(cs.s1_hold) <<< 1);
    s2      = S2_W'(s1) + S2_W'(cs.s2_prev) + (S2_W'(cs.s2_hold) <<< 1);
    s2_sh   = s2 >>> gain_shift;

    cs_nxt = cs;
    if (is_i) begin
      cs_nxt.last_raw = a_x_r;
    end
    if (!sel[1]) begin
      cs_nxt.s1_hold = xv;
    end else begin
      cs_nxt.s1_prev = xv;
      if (sel[2]) begin
        cs_nxt.s2_prev = s1;
      end else begin
        cs_nxt.s2_hold = s1;
      end
    end
  end

  // write back from stage a, in the cycle after the read
  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      chan_mem_r[a_phase_r[0]] <= cs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_vld_r <= '0;
    end else if (a_valid_r) begin
      chan_vld_r[a_phase_r[0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      b_phase_r  <= a_phase_r;
      b_sample_r <= s2_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  assign stage = '{valid: b_valid_r, phase: b_phase_r, sample: b_sample_r};

  // channels alternate, so a read never meets the write-back of the same entry
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && a_valid_r) |-> (phase[0] != a_phase_r[0]))
    else $error("channel state read collides with write-back");

endmodule

// ===== sv/iqssb_hilbert.sv =====
`timescale 1ns / 1ps

module iqssb_hilbert (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  iqssb_pkg::stage_t                     stage,
  output logic signed [iqssb_pkg::DATA_W-1:0]   hilbert,
  output logic signed [iqssb_pkg::S2_W-1:0]     q_center
);

  localparam int S2_W    = iqssb_pkg::S2_W;
  localparam int D_W     = iqssb_pkg::D_W;
  localparam int ACC_W   = iqssb_pkg::ACC_W;
  localparam int H_SHIFT = iqssb_pkg::H_SHIFT;
  localparam int DATA_W  = iqssb_pkg::DATA_W;
  localparam int Q_DEPTH = iqssb_pkg::Q_DEPTH;

  logic signed [S2_W-1:0]   taps_r [Q_DEPTH];
  logic signed [ACC_W-1:0]  part_r;
  logic signed [S2_W-1:0]   midh_r;
  logic signed [DATA_W-1:0] hilbert_r;
  logic signed [S2_W-1:0]   q_center_r;

  logic signed [D_W-1:0]    d2;
  logic signed [D_W-1:0]    d4;
  logic signed [D_W-1:0]    mid;
  logic signed [D_W-1:0]    mid_adj;
  logic signed [ACC_W-1:0]  part_nxt;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_adj;
  logic signed [ACC_W-H_SHIFT-1:0] q_div;
  logic signed [DATA_W-1:0] hilbert_nxt;
  logic                     upd;

  assign upd = stage.valid && (stage.phase == iqssb_pkg::PH_HILBERT);

  // tap-only part of the sum, settles long before the next update
  always_comb begin
    d2       = D_W'(taps_r[2]) - D_W'(taps_r[12]);
    d4       = D_W'(taps_r[4]) - D_W'(taps_r[10]);
    mid      = D_W'(taps_r[6]) - D_W'(taps_r[8]);
    mid_adj  = mid + {{(D_W-1){1'b0}}, mid[D_W-1]};
    part_nxt = ACC_W'(taps_r[0]) * iqssb_pkg::H_C0 + ACC_W'(d2) * iqssb_pkg::H_C2
             + ACC_W'(d4) * iqssb_pkg::H_C4 + ACC_W'(mid) * iqssb_pkg::H_C6;
  end

  always_comb begin
    acc         = part_r - ACC_W'(stage.sample) * iqssb_pkg::H_C0;
    acc_adj     = acc + {{(ACC_W-H_SHIFT){1'b0}}, {H_SHIFT{acc[ACC_W-1]}}};
    q_div       = acc_adj[ACC_W-1:H_SHIFT];
    hilbert_nxt = DATA_W'(q_div) + DATA_W'(midh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < Q_DEPTH; k++) begin
        taps_r[k] <= '0;
      end
      part_r     <= '0;
      midh_r     <= '0;
      hilbert_r  <= '0;
      q_center_r <= '0;
    end else begin
      part_r <= part_nxt;
      midh_r <= mid_adj[D_W-1:1];
      if (upd) begin
        for (int k = 0; k < Q_DEPTH - 1; k++) begin
          taps_r[k] <= taps_r[k+1];
        end
        taps_r[Q_DEPTH-1] <= stage.sample;
        hilbert_r         <= hilbert_nxt;
        q_center_r        <= taps_r[iqssb_pkg::Q_CENTER];
      end
    end
  end

  assign hilbert  = hilbert_r;
  assign q_center = q_center_r;

endmodule

// ===== sv/iqssb_idelay.sv =====
`timescale 1ns / 1ps

module iqssb_idelay #(
  parameter int DEPTH = iqssb_pkg::I_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rd_en,
  input  iqssb_pkg::stage_t                 stage,
  output logic signed [iqssb_pkg::S2_W-1:0] i_out
);

  localparam int S2_W  = iqssb_pkg::S2_W;
  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  // circular buffer, the slot at the pointer holds the oldest sample
  logic signed [S2_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]       vld_r;
  logic [PTR_W-1:0]       ptr_r;
  logic signed [S2_W-1:0] rd_data_r;
  logic                   rd_vld_r;
  logic                   wr_en;

  assign wr_en = stage.valid && (stage.phase == iqssb_pkg::PH_EMIT);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[ptr_r];
    end
    if (wr_en) begin
      mem_r[ptr_r] <= stage.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      ptr_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[ptr_r];
      end
      if (wr_en) begin
        vld_r[ptr_r] <= 1'b1;
        ptr_r        <= (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
      end
    end
  end

  assign i_out = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  localparam int DATA_W       = iqssb_pkg::DATA_W;
  localparam int GAIN_W       = iqssb_pkg::GAIN_W;
  localparam int PHASE_W      = iqssb_pkg::PHASE_W;
  localparam int SAMPLE_W     = iqssb_pkg::SAMPLE_W;
  localparam int NUM_CH       = iqssb_pkg::NUM_CH;
  localparam int I_DEPTH      = iqssb_pkg::I_DEPTH;
  localparam int Q_DEPTH      = iqssb_pkg::Q_DEPTH;
  localparam int Q_CENTER     = iqssb_pkg::Q_CENTER;
  localparam int H_SHIFT      = iqssb_pkg::H_SHIFT;
  localparam int ADC_OFFSET_C = int'(iqssb_pkg::ADC_OFFSET_C);
  localparam int H_C0         = int'(iqssb_pkg::H_C0);
  localparam int H_C2         = int'(iqssb_pkg::H_C2);
  localparam int H_C4         = int'(iqssb_pkg::H_C4);
  localparam int H_C6         = int'(iqssb_pkg::H_C6);

  typedef struct {
    logic signed [DATA_W-1:0] sideband_sum;
    logic signed [DATA_W-1:0] i_sample;
    logic signed [DATA_W-1:0] q_sample;
  } ssb_frame_t;

  class ssb_receiver_mirror;
    logic [GAIN_W-1:0]  gain;
    logic [PHASE_W-1:0] phase;
    int                 s1_hold[NUM_CH];
    int                 s1_prev[NUM_CH];
    int                 s2_hold[NUM_CH];
    int                 s2_prev[NUM_CH];
    int                 last_i;
    int                 i_line[I_DEPTH];
    int                 q_line[Q_DEPTH];
    int                 hilbert;
    int                 q_center;
    ssb_frame_t         frames_due[$];
    int                 n_errors;
    int                 n_frames;

    function new();
      gain     = '0;
      phase    = '0;
      last_i   = 0;
      hilbert  = 0;
      q_center = 0;
      n_errors = 0;
      n_frames = 0;
      foreach (s1_hold[k]) begin
        s1_hold[k] = 0;
        s1_prev[k] = 0;
        s2_hold[k] = 0;
        s2_prev[k] = 0;
      end
      foreach (i_line[k]) i_line[k] = 0;
      foreach (q_line[k]) q_line[k] = 0;
    endfunction

    static function int wrap16(int v);
      return int'(shortint'(v));
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] raw);
      int                 x;
      int                 avg;
      int                 s1;
      int                 s2;
      int                 mid;
      int                 acc;
      int                 ch;
      bit                 is_i;
      logic [PHASE_W-1:0] sel;
      ssb_frame_t         f;
      x    = int'(raw) - int'(ADC_OFFSET_C);
      is_i = !phase[0];
      ch   = is_i ? 0 : 1;
      sel  = is_i ? ~phase : phase;
      if (is_i) begin
        avg    = (last_i + x) / 2;
        last_i = x;
        x      = avg;
      end
      if (sel[1]) begin
        s1 = wrap16(x + s1_prev[ch] + s1_hold[ch] * 2);
        s1_prev[ch] = x;
        if (sel[2]) begin
          s2 = wrap16(s1 + s2_prev[ch] + s2_hold[ch] * 2);
          s2_prev[ch] = s1;
          s2 = wrap16(s2 >>> gain);
          if (is_i) begin
            f.sideband_sum = DATA_W'(wrap16(i_line[0] + hilbert));
            f.i_sample     = DATA_W'(i_line[0]);
            f.q_sample     = DATA_W'(q_center);
            for (int k = 0; k < I_DEPTH - 1; k++) i_line[k] = i_line[k+1];
            i_line[I_DEPTH-1] = s2;
            frames_due.push_back(f);
          end else begin
            mid = q_line[6] - q_line[8];
            acc = (q_line[0] - s2) * int'(H_C0) + (q_line[2] - q_line[12]) * int'(H_C2)
                + (q_line[4] - q_line[10]) * int'(H_C4) + mid * int'(H_C6);
            q_center = q_line[Q_CENTER];
            hilbert  = wrap16(acc / (1 << H_SHIFT) + mid / 2);
            for (int k = 0; k < Q_DEPTH - 1; k++) q_line[k] = q_line[k+1];
            q_line[Q_DEPTH-1] = s2;
          end
        end else begin
          s2_hold[ch] = s1;
        end
      end else begin
        s1_hold[ch] = x;
      end
      phase = phase + 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      n_errors++;
    endtask

    task compare_frame(logic signed [DATA_W-1:0] sum, logic signed [DATA_W-1:0] i_s,
                       logic signed [DATA_W-1:0] q_s);
      ssb_frame_t f;
      if (frames_due.size() == 0) begin
        report($sformatf("unexpected result sum=%0d i=%0d q=%0d", sum, i_s, q_s));
      end else begin
        f = frames_due.pop_front();
        n_frames++;
        if (sum !== f.sideband_sum || i_s !== f.i_sample || q_s !== f.q_sample)
          report($sformatf("result %0d: sum=%0d/%0d i=%0d/%0d q=%0d/%0d (got/exp)",
                           n_frames, sum, f.sideband_sum, i_s, f.i_sample,
                           q_s, f.q_sample));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [GAIN_W-1:0]  cfg_wr_data;

  iqssb_in_if  in_if();
  iqssb_out_if out_if();

  iq_decimating_ssb_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_if),
    .out_ch     (out_if)
  );

  ssb_receiver_mirror mirror = new();

  bit src_burst;
  bit snk_burst;
  int n_samples;
  int n_gain_writes;
  int walk_level;

  localparam int ITEMS_PER_PASS = 200;
  localparam int NUM_PASSES     = 8;
  localparam int MAX_WAIT       = 14;
  localparam int SETTLE_CYCLES  = 6;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

  // result side: random stalls per transfer, none while snk_burst is set
  initial begin
    int w;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      w = snk_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      mirror.compare_frame(out_if.sideband_sum, out_if.i_sample, out_if.q_sample);
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.adc_sample <= s;
    do @(posedge clk); while (!in_if.ready);
    mirror.take_sample(s);
    n_samples++;
  endtask

  task automatic set_gain(input logic [GAIN_W-1:0] g);
    in_if.valid <= 1'b0;
    while (mirror.frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mirror.gain = g;
    n_gain_writes++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return SAMPLE_W'($urandom_range(0, 1023));
    if (sel < 6) return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    if (sel < 8) return SAMPLE_W'($urandom_range(500, 524));
    walk_level = walk_level + $urandom_range(0, 64) - 32;
    if (walk_level < 0) walk_level = 0;
    if (walk_level > 1023) walk_level = 1023;
    return SAMPLE_W'(walk_level);
  endfunction

  initial begin
    int fixed_gains[6] = '{15, 0, 7, 1, 14, 3};
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_if.valid      <= 1'b0;
    in_if.adc_sample <= '0;
    rst_n            <= 1'b0;
    src_burst  = 1'b0;
    snk_burst  = 1'b0;
    walk_level = 512;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full-scale low, full-scale high, then I high against Q low
    set_gain(4'd0);
    repeat (8) send_sample(10'd0);
    repeat (8) send_sample(10'd1023);
    for (int k = 0; k < 8; k++) send_sample(k[0] ? 10'd0 : 10'd1023);

    for (int p = 0; p < NUM_PASSES; p++) begin
      set_gain(GAIN_W'(p < 6 ? fixed_gains[p] : $urandom_range(0, 15)));
      src_burst = (p % 4 == 1) || (p % 4 == 3);
      snk_burst = (p % 4 >= 2);
      repeat (ITEMS_PER_PASS) send_sample(pick_sample());
    end

    in_if.valid <= 1'b0;
    while (mirror.frames_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d samples, %0d output frames, %0d gain writes (0 to 15)",
             n_samples, mirror.n_frames, n_gain_writes);
    $display("idle and stall patterns on both channels, %0d mismatches", mirror.n_errors);
    if (mirror.n_errors == 0 && mirror.frames_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/iqssb_pkg.sv
sv/iqssb_if.sv
sv/iqssb_decim.sv
sv/iqssb_hilbert.sv
sv/iqssb_idelay.sv
sv/iq_decimating_ssb_receiver.sv
test/tb.sv
